[rtl/glb_pkg.sv]
// ----------------------------------------------------------------------------
// glb_pkg: shared types and constants of the line blur
// Pixel layout, job descriptor and back-end sequencer states.
// ----------------------------------------------------------------------------
package glb_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned PX_W   = 32;
  localparam int unsigned ACC_W  = 21;
  localparam int unsigned DIV_W  = 13;
  localparam int unsigned HALF_W = 5;
  localparam int unsigned R_W    = 7;
  localparam int unsigned NSAT_W = 6;
  localparam int unsigned NCH    = 4;

  localparam logic [1:0] CFG_HALF_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_TAPS_LOW     = 2'd1;
  localparam logic [1:0] CFG_TAPS_HIGH    = 2'd2;
  localparam logic [1:0] CFG_KERNEL_TOTAL = 2'd3;

  typedef struct packed {
    logic [HALF_W-1:0] d;
    logic              last;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MAC,
    B_DIV,
    B_HOLD
  } back_state_e;

endpackage

[rtl/gaussian_line_blur_premultiplied_top.sv]
// ----------------------------------------------------------------------------
// gaussian_line_blur_premultiplied_top: premultiplied RGBA line blur
// Symmetric FIR blur of one line of pixels with premultiplied alpha.
// ----------------------------------------------------------------------------
// A pixel is accepted and then holds the input until the taps of its last
// blur job have been accumulated; each result accumulates 2H+1 taps over
// the shared tap multipliers, runs the bit-serial divider by kernel_total
// and, when the blurred alpha is neither 0 nor 255, runs it once more for
// un-premultiplying, and is then handed off to the output register.
// Results of pixel p appear when pixel p+H arrives; the line end flushes the
// remaining H results one after another.
module gaussian_line_blur_premultiplied_top import glb_pkg::*; #(
  parameter int unsigned MAX_HALF_WIDTH = 15,
  parameter int unsigned MAX_LINE       = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [63:0]     cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [CH_W-1:0] in_red_i,
  input  logic [CH_W-1:0] in_green_i,
  input  logic [CH_W-1:0] in_blue_i,
  input  logic [CH_W-1:0] in_alpha_i,
  input  logic            in_line_end_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [CH_W-1:0] out_red_o,
  output logic [CH_W-1:0] out_green_o,
  output logic [CH_W-1:0] out_blue_o,
  output logic [CH_W-1:0] out_alpha_o,
  output logic            out_line_end_o
);

  logic [3:0]       half_width_q;
  logic [63:0]      taps_low_q, taps_high_q;
  logic [DIV_W-1:0] kernel_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q   <= '0;
      taps_low_q     <= 64'd255;
      taps_high_q    <= '0;
      kernel_total_q <= DIV_W'(255);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_WIDTH:   half_width_q   <= cfg_data_i[3:0];
        CFG_TAPS_LOW:     taps_low_q     <= cfg_data_i;
        CFG_TAPS_HIGH:    taps_high_q    <= cfg_data_i;
        CFG_KERNEL_TOTAL: kernel_total_q <= cfg_data_i[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  job_t                  push_job, pop_job;
  logic                  push, pop, full, empty, back_idle;
  logic signed [R_W-1:0] rd_r;
  logic [PX_W-1:0]       rd_px;
  logic [HALF_W-1:0]     h;

  glb_front #(
    .MAX_HALF_WIDTH(MAX_HALF_WIDTH),
    .MAX_LINE      (MAX_LINE)
  ) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .in_red_i, .in_green_i, .in_blue_i, .in_alpha_i, .in_line_end_i,
    .half_width_i(half_width_q),
    .push_o(push), .job_o(push_job), .full_i(full), .empty_i(empty),
    .back_idle_i(back_idle), .rd_r_i(rd_r), .rd_px_o(rd_px), .h_o(h)
  );

  glb_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .job_i(push_job), .full_o(full),
    .pop_i(pop), .job_o(pop_job), .empty_o(empty)
  );

  glb_back u_back (
    .clk_i, .rst_ni, .job_i(pop_job), .empty_i(empty), .pop_o(pop),
    .idle_o(back_idle), .h_i(h), .taps_low_i(taps_low_q),
    .taps_high_i(taps_high_q), .kernel_total_i(kernel_total_q),
    .rd_r_o(rd_r), .rd_px_i(rd_px), .out_valid_o, .out_stall_i,
    .out_red_o, .out_green_o, .out_blue_o, .out_alpha_o, .out_line_end_o
  );

endmodule

[rtl/glb_fifo.sv]
// ----------------------------------------------------------------------------
// glb_fifo: job queue
// Short queue of blur jobs between the front and the back end.
// ----------------------------------------------------------------------------
module glb_fifo import glb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  localparam int unsigned DEPTH = 4;

  job_t       mem_q [DEPTH];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'(DEPTH));
  assign empty_o = (cnt_q == 3'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i)  rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

endmodule

[rtl/glb_front.sv]
// ----------------------------------------------------------------------------
// glb_front: pixel intake
// Premultiplies incoming pixels, keeps the pixel window and issues blur jobs.
// ----------------------------------------------------------------------------
module glb_front import glb_pkg::*; #(
  parameter int unsigned MAX_HALF_WIDTH = 15,
  parameter int unsigned MAX_LINE       = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CH_W-1:0]      in_red_i,
  input  logic [CH_W-1:0]      in_green_i,
  input  logic [CH_W-1:0]      in_blue_i,
  input  logic [CH_W-1:0]      in_alpha_i,
  input  logic                 in_line_end_i,
  input  logic [3:0]           half_width_i,
  output logic                 push_o,
  output job_t                 job_o,
  input  logic                 full_i,
  input  logic                 empty_i,
  input  logic                 back_idle_i,
  input  logic signed [R_W-1:0] rd_r_i,
  output logic [PX_W-1:0]      rd_px_o,
  output logic [HALF_W-1:0]    h_o
);

  localparam int unsigned WIN     = 2 * MAX_HALF_WIDTH + 1;
  localparam int unsigned WIN_W   = $clog2(WIN);
  localparam int unsigned POS_CAP = (MAX_LINE > WIN) ? MAX_LINE : WIN;
  localparam int unsigned POS_W   = $clog2(POS_CAP + 1);

  logic [PX_W-1:0]   win_q [WIN];
  logic [PX_W-1:0]   first_q;
  logic [POS_W-1:0]  pos_q;
  logic [NSAT_W-1:0] nsat_q;
  logic [HALF_W-1:0] h_q, h_cur, gd_q;
  logic              gen_q, single_q, last_q;
  logic              accept, enough;
  logic [PX_W-1:0]   px;

  function automatic logic [CH_W-1:0] premul(logic [CH_W-1:0] c, logic [CH_W-1:0] a);
    logic [15:0] prod;
    logic [16:0] t;
    prod = 16'(c) * 16'(a);
    t    = 17'(prod) + 17'(prod[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  assign h_cur = ({1'b0, half_width_i} > HALF_W'(MAX_HALF_WIDTH)) ?
                 HALF_W'(MAX_HALF_WIDTH) : {1'b0, half_width_i};
  assign enough = (pos_q >= POS_W'(h_cur));
  assign px = {in_alpha_i, premul(in_blue_i, in_alpha_i),
               premul(in_green_i, in_alpha_i), premul(in_red_i, in_alpha_i)};

  assign in_stall_o = gen_q || !empty_i || !back_idle_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = gen_q && !full_i;
  assign job_o      = '{d: gd_q, last: last_q && (gd_q == '0)};
  assign h_o        = h_q;

  always_comb begin
    if (rd_r_i < 0) begin
      rd_px_o = win_q[0];
    end else if (rd_r_i[NSAT_W-1:0] > nsat_q) begin
      rd_px_o = first_q;
    end else begin
      rd_px_o = win_q[rd_r_i[WIN_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q[0] <= px;
      for (int i = 1; i < WIN; i++) win_q[i] <= win_q[i-1];
      if (pos_q == '0) first_q <= px;
      nsat_q <= (pos_q > POS_W'(63)) ? NSAT_W'(63) : NSAT_W'(pos_q);
      h_q    <= h_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      gen_q    <= 1'b0;
      gd_q     <= '0;
      single_q <= 1'b0;
      last_q   <= 1'b0;
    end else if (accept) begin
      gen_q    <= enough || in_line_end_i;
      gd_q     <= enough ? h_cur : HALF_W'(pos_q);
      single_q <= !in_line_end_i;
      last_q   <= in_line_end_i;
      if (in_line_end_i) begin
        pos_q <= '0;
      end else if (pos_q < POS_W'(POS_CAP)) begin
        pos_q <= pos_q + POS_W'(1);
      end
    end else if (push_o) begin
      if (single_q || gd_q == '0) begin
        gen_q <= 1'b0;
      end else begin
        gd_q <= gd_q - HALF_W'(1);
      end
    end
  end

endmodule

[rtl/glb_back.sv]
// ----------------------------------------------------------------------------
// glb_back: blur engine
// Runs one job at a time: tap accumulation, division and un-premultiply.
// ----------------------------------------------------------------------------
module glb_back import glb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  job_t                  job_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  idle_o,
  input  logic [HALF_W-1:0]     h_i,
  input  logic [63:0]           taps_low_i,
  input  logic [63:0]           taps_high_i,
  input  logic [DIV_W-1:0]      kernel_total_i,
  output logic signed [R_W-1:0] rd_r_o,
  input  logic [PX_W-1:0]       rd_px_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CH_W-1:0]       out_red_o,
  output logic [CH_W-1:0]       out_green_o,
  output logic [CH_W-1:0]       out_blue_o,
  output logic [CH_W-1:0]       out_alpha_o,
  output logic                  out_line_end_o
);

  back_state_e state_q, state_d;

  logic [HALF_W-1:0]     d_q;
  logic                  last_q, pass_q;
  logic signed [R_W-1:0] k_q;
  logic [ACC_W-1:0]      num_q [NCH];
  logic [DIV_W-1:0]      rem_q [NCH];
  logic [DIV_W-1:0]      dvs_q;
  logic [4:0]            cnt_q;
  logic [CH_W-1:0]       v_q [NCH];
  logic                  out_valid_q, out_last_q;
  logic [CH_W-1:0]       out_q [NCH];

  logic [ACC_W-1:0]      num_n [NCH];
  logic [DIV_W-1:0]      rem_n [NCH];
  logic [CH_W-1:0]       sat [NCH];
  logic [HALF_W-1:0]     off;
  logic [CH_W-1:0]       w;
  logic                  mac_done, div_done, need_udiv, can_load;

  always_comb begin
    logic [DIV_W:0] t;
    for (int c = 0; c < NCH; c++) begin
      t = {rem_q[c], num_q[c][ACC_W-1]};
      if (t >= {1'b0, dvs_q}) begin
        rem_n[c] = DIV_W'(t - {1'b0, dvs_q});
        num_n[c] = {num_q[c][ACC_W-2:0], 1'b1};
      end else begin
        rem_n[c] = t[DIV_W-1:0];
        num_n[c] = {num_q[c][ACC_W-2:0], 1'b0};
      end
      sat[c] = (num_n[c] > ACC_W'(255)) ? 8'hFF : num_n[c][CH_W-1:0];
    end
  end

  assign off = (k_q < 0) ? HALF_W'(-k_q) : HALF_W'(k_q);
  always_comb begin
    if (off < HALF_W'(8)) begin
      w = taps_low_i[{off[2:0], 3'b000} +: 8];
    end else if (off < HALF_W'(16)) begin
      w = taps_high_i[{off[2:0], 3'b000} +: 8];
    end else begin
      w = '0;
    end
  end

  assign mac_done  = (k_q == R_W'(signed'({1'b0, h_i})));
  assign div_done  = (cnt_q == 5'(ACC_W - 1));
  assign need_udiv = !pass_q && (sat[3] != 8'h00) && (sat[3] != 8'hFF);
  assign can_load  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (!empty_i) state_d = B_MAC;
      B_MAC:  if (mac_done) state_d = B_DIV;
      B_DIV:  if (div_done && !need_udiv) state_d = B_HOLD;
      B_HOLD: if (can_load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = (state_q == B_IDLE) && !empty_i;
    idle_o = (state_q != B_MAC);
    rd_r_o = R_W'(signed'({2'b00, d_q})) - k_q;
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        d_q    <= job_i.d;
        last_q <= job_i.last;
        k_q    <= -R_W'(signed'({1'b0, h_i}));
        for (int c = 0; c < NCH; c++) num_q[c] <= '0;
      end
      B_MAC: begin
        for (int c = 0; c < NCH; c++) begin
          num_q[c] <= num_q[c] + ACC_W'(16'(w) * 16'(rd_px_i[c*CH_W +: CH_W]));
          rem_q[c] <= '0;
        end
        k_q    <= k_q + R_W'(1);
        dvs_q  <= (kernel_total_i == '0) ? DIV_W'(1) : kernel_total_i;
        cnt_q  <= '0;
        pass_q <= 1'b0;
      end
      B_DIV: begin
        if (div_done && need_udiv) begin
          for (int c = 0; c < NCH; c++) begin
            v_q[c]   <= sat[c];
            num_q[c] <= ACC_W'(16'(sat[c]) * 16'd255);
            rem_q[c] <= '0;
          end
          dvs_q  <= DIV_W'(sat[3]);
          cnt_q  <= '0;
          pass_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 5'd1;
          for (int c = 0; c < NCH; c++) begin
            num_q[c] <= num_n[c];
            rem_q[c] <= rem_n[c];
          end
          if (div_done) begin
            if (!pass_q) begin
              for (int c = 0; c < NCH; c++) v_q[c] <= sat[c];
            end else begin
              for (int c = 0; c < NCH - 1; c++) v_q[c] <= sat[c];
            end
          end
        end
      end
      B_HOLD: begin
        if (can_load) begin
          for (int c = 0; c < NCH; c++) out_q[c] <= v_q[c];
          out_last_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_HOLD && can_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_red_o      = out_q[0];
  assign out_green_o    = out_q[1];
  assign out_blue_o     = out_q[2];
  assign out_alpha_o    = out_q[3];
  assign out_line_end_o = out_last_q;

endmodule

[rtl/glb_checker.sv]
// ----------------------------------------------------------------------------
// glb_checker: port-level checks of the line blur
// Watches the top-level ports over time and flags handshake or flow slips.
// ----------------------------------------------------------------------------
module glb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       in_line_end_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_red_o,
  input logic [7:0] out_alpha_o,
  input logic       out_line_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_red_o) && $stable(out_alpha_o)
                                   && $stable(out_line_end_o))
    else $error("stalled result changed");

  a_flush_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_line_end_i |=> in_stall_o)
    else $error("input taken during line-end flush");

  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

endmodule

bind gaussian_line_blur_premultiplied_top glb_checker u_glb_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_line_end_i,
  .out_valid_o, .out_stall_i, .out_red_o, .out_alpha_o, .out_line_end_o
);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the premultiplied RGBA line blur
// Streams lines of pixels through the blur under several kernel settings,
// predicts every blurred pixel in a scoreboard and compares each result.
// ----------------------------------------------------------------------------
module tb_top;
  import glb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class blur_scoreboard;
    int unsigned half_width;
    logic [63:0] taps_low;
    logic [63:0] taps_high;
    int unsigned kernel_total;
    logic [31:0] window[31];
    logic [31:0] first_px;
    int unsigned line_pos;
    logic [32:0] pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      half_width = 0;
      taps_low = 64'd255;
      taps_high = 64'd0;
      kernel_total = 255;
      foreach (window[i]) window[i] = '0;
      first_px = '0;
      line_pos = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        CFG_HALF_WIDTH:   half_width = val[3:0];
        CFG_TAPS_LOW:     taps_low = val;
        CFG_TAPS_HIGH:    taps_high = val;
        CFG_KERNEL_TOTAL: kernel_total = val[12:0];
        default: ;
      endcase
    endfunction

    function int unsigned tap(int unsigned o);
      if (o < 8) return (taps_low >> (8 * o)) & 64'hFF;
      return (taps_high >> (8 * (o - 8))) & 64'hFF;
    endfunction

    function logic [31:0] blur_pixel(int unsigned n, int d, int h);
      int unsigned acc[4];
      int unsigned v[4];
      int unsigned dv;
      int r;
      int unsigned s;
      logic [31:0] px;
      foreach (acc[c]) acc[c] = 0;
      dv = (kernel_total == 0) ? 1 : kernel_total;
      for (int k = -h; k <= h; k++) begin
        r = d - k;
        if (r < 0) px = window[0];
        else if (r > int'(n)) px = first_px;
        else px = window[r % 31];
        for (int c = 0; c < 4; c++)
          acc[c] += tap(k < 0 ? -k : k) * px[8*c +: 8];
      end
      for (int c = 0; c < 4; c++) begin
        v[c] = acc[c] / dv;
        if (v[c] > 255) v[c] = 255;
      end
      if (v[3] != 0 && v[3] != 255)
        for (int c = 0; c < 3; c++) begin
          s = v[c] * 255 / v[3];
          v[c] = s > 255 ? 255 : s;
        end
      return {v[3][7:0], v[2][7:0], v[1][7:0], v[0][7:0]};
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                             logic last);
      logic [31:0] px;
      int h;
      int unsigned n;
      int d;
      int cnt;
      h = half_width;
      n = line_pos;
      cnt = 0;
      px = {a, 8'(int'(b) * a / 255), 8'(int'(g) * a / 255), 8'(int'(r) * a / 255)};
      for (int i = 30; i > 0; i--) window[i] = window[i - 1];
      window[0] = px;
      if (n == 0) first_px = px;
      if (int'(n) >= h) begin
        pending.push_back({1'b0, blur_pixel(n, h, h)});
        cnt = 1;
      end
      if (last) begin
        d = (int'(n) >= h) ? h : n + 1;
        while (d > 0) begin
          d--;
          pending.push_back({1'b0, blur_pixel(n, d, h)});
          cnt++;
        end
        if (cnt > 0) pending[$][32] = 1'b1;
        line_pos = 0;
      end else if (line_pos < 4096) begin
        line_pos++;
      end
    endfunction

    task check_result(logic [31:0] got, logic le);
      logic [32:0] want;
      checked++;
      if (pending.size() == 0) begin
        report("result with nothing expected", 0, got);
        return;
      end
      want = pending.pop_front();
      for (int c = 0; c < 4; c++)
        if (want[8*c +: 8] !== got[8*c +: 8])
          report($sformatf("channel %0d", c), want[8*c +: 8], got[8*c +: 8]);
      if (want[32] !== le) report("line end flag", want[32], le);
    endtask

    task report(string what, longint unsigned want, longint unsigned got);
      errors++;
      $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_HALF_WIDTH;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_red_i = '0, in_green_i = '0, in_blue_i = '0, in_alpha_i = '0;
  logic        in_line_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic        out_line_end_o;

  blur_scoreboard sb = new();
  bit          quiet_stall = 0;
  int unsigned pixels_sent = 0;

  gaussian_line_blur_premultiplied_top dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Valid stays high after an accepted transaction until the next pixel or a
  // drain takes it over in the same time step.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
                            logic last);
    int gap;
    gap = quiet_stall ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_red_i <= r;
    in_green_i <= g;
    in_blue_i <= b;
    in_alpha_i <= a;
    in_line_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(r, g, b, a, last);
    pixels_sent++;
  endtask

  task automatic send_line(int len, int mode);
    logic [7:0] a;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: a = 8'd255;
        1: a = 8'd0;
        default: a = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1) * 255)
                                                 : 8'($urandom);
      endcase
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), a, i == len - 1);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic load_kernel(int h, logic [63:0] lo, logic [63:0] hi, int tot);
    write_reg(CFG_HALF_WIDTH, 64'(h));
    write_reg(CFG_TAPS_LOW, lo);
    write_reg(CFG_TAPS_HIGH, hi);
    write_reg(CFG_KERNEL_TOTAL, 64'(tot));
  endtask

  // Before each result the output side stalls for a drawn number of cycles.
  initial begin
    int wait_n;
    repeat (8) @(posedge clk_i);
    forever begin
      wait_n = quiet_stall ? 0 : $urandom_range(0, 5);
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({out_alpha_o, out_blue_o, out_green_o, out_red_o}, out_line_end_o);
  end

  initial begin
    logic [63:0] lo, hi;
    int h, tot;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Reset kernel: identity with a single tap of 255.
    send_pixel(8'hFF, 8'h00, 8'h80, 8'hFF, 1'b0);
    send_pixel(8'h00, 8'hFF, 8'h01, 8'h00, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'hFF, 8'h01, 1'b0);
    send_pixel(8'hAA, 8'h55, 8'h7F, 8'h80, 1'b1);
    drain();
    // Widest kernel, all taps at maximum, divisor zero and divisor 7905 (sum of all taps).
    load_kernel(15, '1, '1, 0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFE, 1'b0);
    send_pixel(8'h01, 8'h02, 8'h03, 8'h7F, 1'b1);
    drain();
    write_reg(CFG_KERNEL_TOTAL, 64'd7905);
    send_line(3, 2);
    send_line(1, 0);
    send_line(20, 1);
    drain();
    // Small kernel with a line longer than the window.
    load_kernel(2, 64'h0000_0000_0040_8060, 64'h0, 448);
    send_line(40, 2);
    drain();
    // Half width change in the middle of a line.
    send_line(2, 0);
    send_pixel(8'h10, 8'h20, 8'h30, 8'h40, 1'b0);
    send_pixel(8'h50, 8'h60, 8'h70, 8'h80, 1'b0);
    drain();
    write_reg(CFG_HALF_WIDTH, 64'd4);
    send_pixel(8'h90, 8'hA0, 8'hB0, 8'hC0, 1'b1);
    drain();
    quiet_stall = 1;
    send_line(6, 2);
    drain();
    quiet_stall = 0;
    for (int phase = 0; phase < 8; phase++) begin
      h = (phase == 0) ? 0 : (phase == 1) ? 15 : $urandom_range(1, 6);
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      tot = (phase == 2) ? 1 : $urandom_range(1, 7905);
      load_kernel(h, lo, hi, tot);
      for (int ln = 0; ln < 4; ln++)
        send_line(($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                                              : $urandom_range(4, 12),
                  ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : 2);
      drain();
    end
    $display("Sent %0d pixels and checked %0d blurred pixels over several kernels.",
             pixels_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/glb_pkg.sv
rtl/glb_fifo.sv
rtl/glb_front.sv
rtl/glb_back.sv
rtl/gaussian_line_blur_premultiplied_top.sv
rtl/glb_checker.sv
dv/tb_top.sv
